// ----- design/tto_pkg.sv -----
// Shared types, constants and codes for the timer table.
// No dependencies; every other design file imports this package.
package tto_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int MAX_RESULTS = 16;

	localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
	localparam int RES_W  = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] REQ_ADD_ONESHOT  = 2'd0;
	localparam logic [1:0] REQ_ADD_PERIODIC = 2'd1;
	localparam logic [1:0] REQ_CANCEL       = 2'd2;
	localparam logic [1:0] REQ_TICK         = 2'd3;

	localparam logic [2:0] EV_ADDED     = 3'd0;
	localparam logic [2:0] EV_EXPIRED   = 3'd1;
	localparam logic [2:0] EV_CANCELLED = 3'd2;
	localparam logic [2:0] EV_FULL      = 3'd3;
	localparam logic [2:0] EV_NOT_FOUND = 3'd4;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_CANCEL,
		OP_TICK
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic        periodic;
		logic [31:0] id;
		logic [31:0] expiry;
		logic [30:0] period;
	} slot_rec_t;

	typedef struct packed {
		logic              we;
		logic              vset;
		logic              vclr;
		logic [SLOT_W-1:0] idx;
		slot_rec_t         rec;
	} slot_wr_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] idx;
		slot_rec_t         rec;
	} slot_rd_t;

	typedef struct packed {
		logic        clr;
		logic        en;
		op_t         op;
		logic [31:0] now;
		logic [31:0] cid;
	} pick_ctl_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
		slot_rec_t         rec;
	} pick_res_t;

endpackage

// ----- design/tto_slot_store.sv -----
// Timer slot storage: record memory with one registered read port and one
// write port, plus per-slot valid flops. Depends on tto_pkg.
module tto_slot_store import tto_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] raddr,
	input  slot_wr_t          wr,
	output logic              rd_valid,
	output slot_rec_t         rd_rec
);

	slot_rec_t             mem [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] valid_q;
	logic                   rd_valid_q;
	slot_rec_t              rd_rec_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.idx] <= wr.rec;
		end
		rd_rec_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.vset) begin
				valid_q[wr.idx] <= 1'b1;
			end else if (wr.vclr) begin
				valid_q[wr.idx] <= 1'b0;
			end
			rd_valid_q <= valid_q[raddr];
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_rec   = rd_rec_q;

endmodule

// ----- design/tto_pick_unit.sv -----
// Shared compare unit: judges one slot per cycle against the best so far.
// Free-slot, id-match and most-overdue searches. Depends on tto_pkg.
module tto_pick_unit import tto_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pick_ctl_t ctl,
	input  slot_rd_t  rd,
	output pick_res_t res
);

	logic              found_q;
	logic [SLOT_W-1:0] idx_q;
	slot_rec_t         rec_q;
	logic [30:0]       late_q;

	logic [31:0] late;
	logic        due;
	logic        take;

	assign late = ctl.now - rd.rec.expiry;
	assign due  = rd.valid && !late[31];

	always_comb begin
		case (ctl.op)
			OP_ADD:    take = !rd.valid && !found_q;
			OP_CANCEL: take = rd.valid && (rd.rec.id == ctl.cid) && !found_q;
			OP_TICK:   take = due && (!found_q || (late[30:0] > late_q) ||
				((late[30:0] == late_q) && (rd.rec.id < rec_q.id)));
			default:   take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clr) begin
			found_q <= 1'b0;
		end else if (ctl.en && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && take && !ctl.clr) begin
			idx_q  <= rd.idx;
			rec_q  <= rd.rec;
			late_q <= late[30:0];
		end
	end

	assign res.found = found_q;
	assign res.idx   = idx_q;
	assign res.rec   = rec_q;

endmodule

// ----- design/timer_table_oneshot_periodic.sv -----
// Timer table top level: request decode, scan sequencer, output register.
// Depends on tto_pkg, tto_slot_store and tto_pick_unit.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+------------------------------------------
//  request | req_valid | req_ready | req_type, duration_ms, cancel_id
//  event   | evt_valid | evt_ready | event_kind, event_id, last_of_run
//
// Add and cancel run accept, one scan over the slot memory (one slot per cycle
// through the registered read port), then one decide step. A tick with no expiry
// runs the same steps. A tick with expiries runs one full scan per reported timer
// plus a final scan that finds none or meets the MAX_RESULTS cap, and three
// decide steps (show, hand off, load) per word after the first, set by the
// single read port of the slot memory and the one shared compare unit.
// Reset clears time, id counter and all valid bits at once; no clearing pass.
// A stalled event output holds the sequencer only at the decide step; a new
// request is taken while the final word of the previous one still waits.
module timer_table_oneshot_periodic import tto_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [30:0] duration_ms,
	input  logic [31:0] cancel_id,
	output logic        evt_valid,
	input  logic        evt_ready,
	output logic [2:0]  event_kind,
	output logic [31:0] event_id,
	output logic        last_of_run
);

	// sequencer and request state
	state_t      state_q, state_nxt;
	op_t         op_q;
	logic        periodic_q;
	logic [30:0] dur_q;
	logic [31:0] cid_q;
	logic [31:0] time_q;
	logic [31:0] next_id_q;
	logic [CNT_W-1:0] scan_cnt_q;
	logic [RES_W-1:0] n_q;

	// read pipeline tag: slot whose data arrives this cycle
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_idx_s1;

	// output word register; hold_q = loaded but not yet shown (last unknown)
	logic        out_valid_q;
	logic        hold_q;
	logic [2:0]  kind_q;
	logic [31:0] id_q;
	logic        last_q;

	logic      req_acc;
	logic      scan_done;
	logic      more;
	logic      out_load, out_show, out_last, id_inc, n_inc, rescan;
	logic [2:0]  load_kind;
	logic [31:0] load_id;
	slot_wr_t  wr;
	pick_ctl_t pctl;
	pick_res_t pres;
	slot_rd_t  srd;
	logic      rd_valid;
	slot_rec_t rd_rec;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign scan_done = (scan_cnt_q == CNT_W'(TIMER_SLOTS));
	assign more      = pres.found && (n_q < RES_W'(MAX_RESULTS));

	tto_slot_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.raddr    (scan_cnt_q[SLOT_W-1:0]),
		.wr       (wr),
		.rd_valid (rd_valid),
		.rd_rec   (rd_rec)
	);

	assign srd.valid = rd_valid;
	assign srd.idx   = rd_idx_s1;
	assign srd.rec   = rd_rec;

	assign pctl.clr = req_acc || rescan;
	assign pctl.en  = rd_vld_s1;
	assign pctl.op  = op_q;
	assign pctl.now = time_q;
	assign pctl.cid = cid_q;

	tto_pick_unit u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pctl),
		.rd     (srd),
		.res    (pres)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_nxt = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (op_q == OP_TICK) begin
					if (more) begin
						if (!hold_q && !out_valid_q) begin
							state_nxt = ST_SCAN;
						end
					end else begin
						state_nxt = ST_IDLE;
					end
				end else if (!out_valid_q) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// decide-step actions
	always_comb begin
		out_load  = 1'b0;
		out_show  = 1'b0;
		out_last  = 1'b0;
		load_kind = EV_ADDED;
		load_id   = '0;
		id_inc    = 1'b0;
		n_inc     = 1'b0;
		rescan    = 1'b0;
		wr        = '0;
		wr.idx    = pres.idx;
		wr.rec    = pres.rec;
		case (state_q)
			ST_DECIDE: begin
				case (op_q)
					OP_ADD: begin
						if (!out_valid_q) begin
							out_load = 1'b1;
							out_show = 1'b1;
							out_last = 1'b1;
							if (pres.found) begin
								load_kind       = EV_ADDED;
								load_id         = next_id_q;
								id_inc          = 1'b1;
								wr.we           = 1'b1;
								wr.vset         = 1'b1;
								wr.rec.periodic = periodic_q;
								wr.rec.id       = next_id_q;
								wr.rec.expiry   = time_q + {1'b0, dur_q};
								wr.rec.period   = dur_q;
							end else begin
								load_kind = EV_FULL;
								load_id   = '0;
							end
						end
					end
					OP_CANCEL: begin
						if (!out_valid_q) begin
							out_load  = 1'b1;
							out_show  = 1'b1;
							out_last  = 1'b1;
							load_id   = cid_q;
							load_kind = pres.found ? EV_CANCELLED : EV_NOT_FOUND;
							wr.vclr   = pres.found;
						end
					end
					OP_TICK: begin
						if (more) begin
							if (hold_q) begin
								// another expiry follows: show held word as not last
								out_show = 1'b1;
							end else if (!out_valid_q) begin
								out_load  = 1'b1;
								load_kind = EV_EXPIRED;
								load_id   = pres.rec.id;
								n_inc     = 1'b1;
								rescan    = 1'b1;
								if (pres.rec.periodic) begin
									wr.we         = 1'b1;
									wr.rec.expiry = pres.rec.expiry + {1'b0, pres.rec.period};
								end else begin
									wr.vclr = 1'b1;
								end
							end
						end else if (hold_q) begin
							out_show = 1'b1;
							out_last = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_q      <= '0;
			next_id_q   <= '0;
			scan_cnt_q  <= '0;
			n_q         <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			hold_q      <= 1'b0;
			op_q        <= OP_ADD;
		end else begin
			state_q <= state_nxt;
			if (req_acc) begin
				case (req_type)
					REQ_ADD_ONESHOT:  op_q <= OP_ADD;
					REQ_ADD_PERIODIC: op_q <= OP_ADD;
					REQ_CANCEL:       op_q <= OP_CANCEL;
					REQ_TICK:         op_q <= OP_TICK;
					default:          op_q <= OP_TICK;
				endcase
				if (req_type == REQ_TICK) begin
					time_q <= time_q + 32'd1;
				end
				n_q <= '0;
			end else if (n_inc) begin
				n_q <= n_q + RES_W'(1);
			end
			if (id_inc) begin
				next_id_q <= next_id_q + 32'd1;
			end
			if (req_acc || rescan) begin
				scan_cnt_q <= '0;
			end else if (state_q == ST_SCAN && !scan_done) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end
			rd_vld_s1 <= (state_q == ST_SCAN) && !scan_done;
			if (out_show) begin
				out_valid_q <= 1'b1;
			end else if (evt_ready) begin
				out_valid_q <= 1'b0;
			end
			if (out_show) begin
				hold_q <= 1'b0;
			end else if (out_load) begin
				hold_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_cnt_q[SLOT_W-1:0];
		if (req_acc) begin
			periodic_q <= (req_type == REQ_ADD_PERIODIC);
			dur_q      <= (duration_ms == 31'd0) ? 31'd1 : duration_ms;
			cid_q      <= cancel_id;
		end
		if (out_load) begin
			kind_q <= load_kind;
			id_q   <= load_id;
		end
		if (out_show) begin
			last_q <= out_last;
		end
	end

	assign evt_valid   = out_valid_q;
	assign event_kind  = kind_q;
	assign event_id    = id_q;
	assign last_of_run = last_q;

	// a held word is never on the port at the same time
	a_hold_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q |-> !out_valid_q)
		else $error("held word visible on event port");

	// no run is left with an unshown word once idle
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_q)
		else $error("idle with held word");

	// a non-final word means the tick is still running
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && !last_of_run) |-> (state_q != ST_IDLE))
		else $error("non-final word while idle");

	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RES_W'(MAX_RESULTS))
		else $error("expiry count above cap");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == ST_SCAN) && (scan_cnt_q == '0))
		else $error("request accepted without scan start");

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for the timer table: directed plan, then random traffic.
// Depends on tto_pkg and timer_table_oneshot_periodic; predicts events in-line.
`timescale 1ns / 1ps

module testbench;
	import tto_pkg::*;

	// Longest stretch with no accepted word before the run is declared hung.
	// The slowest legitimate gap is the forced sink hold-off plus one full tick.
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int SINK_HOLD      = 1500;
	localparam int RANDOM_WORDS   = 204;
	localparam int DRAIN_CYCLES   = 400;
	localparam int PLAN_ROWS      = 13;
	// Outstanding predictions never exceed one full run plus one final word.
	localparam int EXP_DEPTH      = 64;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] id;
		logic        last;
	} evt_word_t;

	// One line of the directed plan. reps repeats the row; typed rows carry
	// their single event, the rest are left to the predictor.
	typedef struct packed {
		logic [1:0]  rtype;
		logic [30:0] dur;
		logic [31:0] cid;
		logic [4:0]  reps;
		logic        typed;
		logic [2:0]  kind;
		logic [31:0] id;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  req_type;
	logic [30:0] duration_ms;
	logic [31:0] cancel_id;
	logic        evt_valid;
	logic        evt_ready;
	logic [2:0]  event_kind;
	logic [31:0] event_id;
	logic        last_of_run;

	// Typed expectation travels with the request word it belongs to.
	logic        stim_typed;
	logic [2:0]  stim_kind;
	logic [31:0] stim_id;

	// Predictor copy of the table.
	logic [31:0] tbl_now;
	logic [31:0] tbl_next_id;
	logic        tbl_live     [TIMER_SLOTS];
	logic        tbl_periodic [TIMER_SLOTS];
	logic [31:0] tbl_id       [TIMER_SLOTS];
	logic [31:0] tbl_expiry   [TIMER_SLOTS];
	logic [30:0] tbl_period   [TIMER_SLOTS];

	evt_word_t   run_events [MAX_RESULTS];
	int          run_len;

	// Pending predictions, oldest at exp_head.
	evt_word_t   exp_buf [EXP_DEPTH];
	int          exp_head  = 0;
	int          exp_count = 0;

	int          mismatches     = 0;
	int          words_sent;
	int          adds_sent;
	int          stalled_cycles = 0;
	plan_row_t   plan [PLAN_ROWS];
	int          plan_len = 0;

	timer_table_oneshot_periodic dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.duration_ms (duration_ms),
		.cancel_id   (cancel_id),
		.evt_valid   (evt_valid),
		.evt_ready   (evt_ready),
		.event_kind  (event_kind),
		.event_id    (event_id),
		.last_of_run (last_of_run)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void add_row(input plan_row_t row);
		plan[plan_len] = row;
		plan_len++;
	endfunction

	function automatic void expect_word(input evt_word_t w);
		exp_buf[(exp_head + exp_count) % EXP_DEPTH] = w;
		exp_count++;
	endfunction

	// Apply one request word to the predicted table; events land in run_events.
	function automatic void advance_timer_table(input logic [1:0] rt, input logic [30:0] dur_in,
			input logic [31:0] cid);
		logic [30:0] dur;
		logic [31:0] late;
		logic [31:0] best_late;
		int          slot;
		int          best;
		int          i;
		bit          done;
		dur = (dur_in == '0) ? 31'd1 : dur_in;   // zero delay behaves as one
		run_len = 0;
		case (rt)
			REQ_ADD_ONESHOT, REQ_ADD_PERIODIC: begin
				slot = -1;
				for (i = 0; i < TIMER_SLOTS; i++)
					if (slot < 0 && !tbl_live[i])
						slot = i;
				if (slot < 0) begin
					// full: id counter untouched
					run_events[0] = '{EV_FULL, 32'd0, 1'b1};
				end else begin
					tbl_live[slot]     = 1'b1;
					tbl_periodic[slot] = (rt == REQ_ADD_PERIODIC);
					tbl_id[slot]       = tbl_next_id;
					tbl_expiry[slot]   = tbl_now + {1'b0, dur};
					tbl_period[slot]   = dur;
					run_events[0]      = '{EV_ADDED, tbl_next_id, 1'b1};
					tbl_next_id        = tbl_next_id + 32'd1;
				end
				run_len = 1;
			end
			REQ_CANCEL: begin
				slot = -1;
				for (i = 0; i < TIMER_SLOTS; i++)
					if (slot < 0 && tbl_live[i] && tbl_id[i] == cid)
						slot = i;
				if (slot < 0) begin
					run_events[0] = '{EV_NOT_FOUND, cid, 1'b1};
				end else begin
					tbl_live[slot] = 1'b0;
					run_events[0]  = '{EV_CANCELLED, cid, 1'b1};
				end
				run_len = 1;
			end
			default: begin
				tbl_now = tbl_now + 32'd1;
				done = 1'b0;
				while (!done && run_len < MAX_RESULTS) begin
					// most overdue first, ties to the lower id
					best = -1;
					best_late = '0;
					for (i = 0; i < TIMER_SLOTS; i++) begin
						late = tbl_now - tbl_expiry[i];
						if (tbl_live[i] && !late[31]) begin
							if (best < 0 || late > best_late ||
									(late == best_late && tbl_id[i] < tbl_id[best])) begin
								best = i;
								best_late = late;
							end
						end
					end
					if (best < 0) begin
						done = 1'b1;
					end else begin
						run_events[run_len] = '{EV_EXPIRED, tbl_id[best], 1'b0};
						run_len++;
						if (tbl_periodic[best])
							tbl_expiry[best] = tbl_expiry[best] + {1'b0, tbl_period[best]};
						else
							tbl_live[best] = 1'b0;
					end
				end
				if (run_len > 0)
					run_events[run_len - 1].last = 1'b1;
			end
		endcase
	endfunction

	// Idle length: mostly none, some short, a few long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(12, 45);
	endfunction

	// Checker: compare every accepted event word with the oldest prediction,
	// then predict for a request word accepted on the same edge. A request's
	// own events can never appear on its acceptance edge.
	always @(posedge clk) begin : scoreboard
		evt_word_t want;
		int        k;
		if (arst_n) begin
			if (evt_valid && evt_ready) begin
				if (exp_count == 0) begin
					mismatches++;
					$display("%0t: event word with none expected: kind %0d id %0h last %0b",
						$time, event_kind, event_id, last_of_run);
				end else begin
					want = exp_buf[exp_head];
					exp_head = (exp_head + 1) % EXP_DEPTH;
					exp_count--;
					if (event_kind !== want.kind) begin
						mismatches++;
						$display("%0t: event_kind expected %0d actual %0d",
							$time, want.kind, event_kind);
					end
					if (event_id !== want.id) begin
						mismatches++;
						$display("%0t: event_id expected %0h actual %0h",
							$time, want.id, event_id);
					end
					if (last_of_run !== want.last) begin
						mismatches++;
						$display("%0t: last_of_run expected %0b actual %0b",
							$time, want.last, last_of_run);
					end
				end
			end
			if (req_valid && req_ready) begin
				advance_timer_table(req_type, duration_ms, cancel_id);
				if (stim_typed)
					expect_word('{stim_kind, stim_id, 1'b1});
				else
					for (k = 0; k < run_len; k++)
						expect_word(run_events[k]);
			end
		end
	end

	// Hang detector: any accepted word on either side restarts the count.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (evt_valid && evt_ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Event sink: random ready pattern plus one long hold-off so the table
	// backs up and the request side stalls.
	initial begin : sink
		bit held;
		held = 1'b0;
		evt_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && words_sent >= 60) begin
				held = 1'b1;
				evt_ready <= 1'b0;
				repeat (SINK_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 2) != 0) begin
				evt_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else begin
				evt_ready <= 1'b0;
				repeat (1 + idle_len()) @(posedge clk);
			end
		end
	end

	// Offer one request word after gap idle cycles and hold it until taken.
	task automatic offer_word(input logic [1:0] rt, input logic [30:0] dur, input logic [31:0] cid,
			input logic typed, input logic [2:0] kind, input logic [31:0] id, input int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= rt;
		duration_ms <= dur;
		cancel_id   <= cid;
		stim_typed  <= typed;
		stim_kind   <= kind;
		stim_id     <= id;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		words_sent++;
		if (rt == REQ_ADD_ONESHOT || rt == REQ_ADD_PERIODIC)
			adds_sent++;
	endtask

	initial begin : source
		plan_row_t   row;
		logic [1:0]  rt;
		logic [30:0] dur;
		logic [31:0] cid;
		int          i;
		int          r;
		int          n;
		int          burst_left;

		arst_n      = 1'b0;
		req_valid   <= 1'b0;
		req_type    <= REQ_TICK;
		duration_ms <= '0;
		cancel_id   <= '0;
		stim_typed  <= 1'b0;
		stim_kind   <= EV_ADDED;
		stim_id     <= '0;
		words_sent     = 0;
		adds_sent      = 0;
		burst_left     = 0;
		tbl_now        = '0;
		tbl_next_id    = '0;
		for (i = 0; i < TIMER_SLOTS; i++) begin
			tbl_live[i]     = 1'b0;
			tbl_periodic[i] = 1'b0;
			tbl_id[i]       = '0;
			tbl_expiry[i]   = '0;
			tbl_period[i]   = '0;
		end

		// Directed plan. Time is 1 after the first tick, so the first 16 adds
		// all fall due together on the next tick: a full run of expiries.
		add_row('{REQ_TICK,         31'd0, 32'd0, 5'd1, 1'b0, EV_ADDED, 32'd0});
		add_row('{REQ_CANCEL,       31'd5, 32'd0, 5'd1, 1'b1, EV_NOT_FOUND, 32'd0});
		// zero delay counts as one
		add_row('{REQ_ADD_ONESHOT,  31'd0, 32'd0, 5'd1, 1'b1, EV_ADDED, 32'd0});
		add_row('{REQ_ADD_PERIODIC, 31'd1, 32'd0, 5'd1, 1'b1, EV_ADDED, 32'd1});
		add_row('{REQ_ADD_ONESHOT,  31'd1, 32'hFFFF_FFFF, 5'd14, 1'b0, EV_ADDED, 32'd0});
		// table full, id counter not consumed
		add_row('{REQ_ADD_PERIODIC, 31'd5, 32'd0, 5'd1, 1'b1, EV_FULL, 32'd0});
		add_row('{REQ_TICK,         31'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0,
			EV_ADDED, 32'd0});
		add_row('{REQ_ADD_PERIODIC, 31'h7FFF_FFFF, 32'd0, 5'd1, 1'b1, EV_ADDED, 32'd16});
		add_row('{REQ_ADD_ONESHOT,  31'd2, 32'd0, 5'd1, 1'b1, EV_ADDED, 32'd17});
		add_row('{REQ_CANCEL,       31'd0, 32'd16, 5'd1, 1'b1, EV_CANCELLED, 32'd16});
		add_row('{REQ_CANCEL,       31'd0, 32'hFFFF_FFFF, 5'd1, 1'b1, EV_NOT_FOUND,
			32'hFFFF_FFFF});
		add_row('{REQ_TICK,         31'd0, 32'd0, 5'd1, 1'b0, EV_ADDED, 32'd0});
		// periodic id 1 and one-shot id 17 tie on expiry: lower id first
		add_row('{REQ_TICK,         31'd0, 32'd0, 5'd1, 1'b0, EV_ADDED, 32'd0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < plan_len; i++) begin
			row = plan[i];
			repeat (row.reps)
				offer_word(row.rtype, row.dur, row.cid, row.typed, row.kind, row.id, idle_len());
		end

		// Random traffic: mostly short delays and cancels aimed at recent ids so
		// timers really fire and get removed; the rest is full-range noise.
		for (n = 0; n < RANDOM_WORDS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 36)
				rt = REQ_TICK;
			else if (r < 70)
				rt = $urandom_range(0, 1) ? REQ_ADD_PERIODIC : REQ_ADD_ONESHOT;
			else
				rt = REQ_CANCEL;

			r = $urandom_range(0, 99);
			if (r < 70)
				dur = 31'($urandom_range(1, 8));
			else if (r < 85)
				dur = 31'($urandom_range(9, 64));
			else if (r < 95)
				dur = 31'($urandom);
			else
				dur = '0;

			r = $urandom_range(0, 99);
			if (r < 65)
				cid = 32'(adds_sent) - 32'($urandom_range(1, 20));
			else if (r < 90)
				cid = $urandom;
			else
				cid = 32'($urandom_range(0, 3));

			// back-to-back bursts now and then
			if (burst_left == 0 && $urandom_range(0, 15) == 0)
				burst_left = $urandom_range(8, 24);
			if (burst_left > 0) begin
				burst_left--;
				offer_word(rt, dur, cid, 1'b0, EV_ADDED, 32'd0, 0);
			end else begin
				offer_word(rt, dur, cid, 1'b0, EV_ADDED, 32'd0, idle_len());
			end
		end
		req_valid <= 1'b0;

		while (exp_count != 0)
			@(posedge clk);
		// let any stray word show up
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
